FILE: hdl/assert_macros.svh
// Concurrent assertion macros for the list table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/ult_pkg.sv
// Shared constants, operation and status codes and result type for the list table.
`default_nettype none

package ult_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned COUNT_W      = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEAD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
  } ult_res_t;

endpackage

`default_nettype wire

FILE: hdl/ult_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ult_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read; the registered read data appears in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/ult_ctrl.sv
// Sequencer that walks the entry memory for append, head insert, search and remove.
`default_nettype none

module ult_ctrl #(
  parameter int unsigned CAPACITY = ult_pkg::CAPACITY_DEF,
  localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Request side
  input  wire logic                            in_valid,
  input  wire logic [ult_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [ult_pkg::DATA_W-1:0]      in_value,
  output logic                                 in_stall,
  // Result side
  output ult_pkg::ult_res_t                    res,
  input  wire logic                            res_ready,
  // Entry memory
  output logic                                 mem_we,
  output logic      [IDX_W-1:0]                mem_waddr,
  output logic      [ult_pkg::DATA_W-1:0]      mem_wdata,
  output logic      [IDX_W-1:0]                mem_raddr,
  input  wire logic [ult_pkg::DATA_W-1:0]      mem_rdata
);

  localparam int unsigned PW = (IDX_W > ult_pkg::POS_W) ? IDX_W : ult_pkg::POS_W;
  localparam int unsigned CW = (CNT_W > ult_pkg::COUNT_W) ? CNT_W : ult_pkg::COUNT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              ptr_r, ptr_nxt;
  logic                          pend_r, pend_nxt;
  logic [IDX_W-1:0]              src_r, src_nxt;
  logic [IDX_W-1:0]              pos_r, pos_nxt;
  logic [ult_pkg::DATA_W-1:0]    key_r, key_nxt;
  logic                          rm_r, rm_nxt;
  logic [ult_pkg::STATUS_W-1:0]  status_r, status_nxt;

  logic                          full;
  logic                          hit;
  logic [CNT_W-1:0]              cnt_m1;
  logic [CNT_W-1:0]              ptr_m1;
  logic [PW-1:0]                 pos_wide;
  logic [CW-1:0]                 cnt_wide;

  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign hit    = pend_r && (mem_rdata == key_r);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign ptr_m1 = ptr_r - CNT_W'(1);

  // Step the sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = pend_r;
    src_nxt    = src_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    rm_nxt     = rm_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = cnt_r[IDX_W-1:0];
    mem_wdata  = in_value;
    mem_raddr  = ptr_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt    = '0;
          status_nxt = ult_pkg::ST_OK;
          key_nxt    = in_value;
          pend_nxt   = 1'b0;
          case (in_func)
            ult_pkg::FUNC_APPEND: begin
              state_nxt = S_DONE;
              if (full) begin
                status_nxt = ult_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            ult_pkg::FUNC_HEAD: begin
              if (full) begin
                status_nxt = ult_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = cnt_r;
                state_nxt = S_SHIFT;
              end
            end
            default: begin
              // search, or remove that starts with a search
              ptr_nxt   = '0;
              rm_nxt    = (in_func != ult_pkg::FUNC_SEARCH);
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          pos_nxt   = src_r;
          state_nxt = rm_r ? S_LAST : S_DONE;
        end else if (ptr_r == cnt_r) begin
          status_nxt = ult_pkg::ST_NOT_FOUND;
          pos_nxt    = '0;
          state_nxt  = S_DONE;
        end else begin
          // issue the next read, compare it in the next cycle
          src_nxt  = ptr_r[IDX_W-1:0];
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CNT_W'(1);
        end
      end

      S_LAST: begin
        // fetch the tail entry to fill the hole
        mem_raddr = cnt_m1[IDX_W-1:0];
        state_nxt = S_MOVE;
      end

      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = mem_rdata;
        cnt_nxt   = cnt_m1;
        state_nxt = S_DONE;
      end

      S_SHIFT: begin
        // write back the entry read last cycle one slot higher
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = src_r + IDX_W'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_r != '0) begin
          mem_raddr = ptr_m1[IDX_W-1:0];
          src_nxt   = ptr_m1[IDX_W-1:0];
          pend_nxt  = 1'b1;
          ptr_nxt   = ptr_m1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = key_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Hold working values
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    src_r    <= src_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    rm_r     <= rm_nxt;
    status_r <= status_nxt;
  end

  // Fit position and count to the result fields
  assign pos_wide = PW'(pos_r);
  assign cnt_wide = CW'(cnt_r);

  assign in_stall     = (state_r != S_IDLE);
  assign res.valid    = (state_r == S_DONE);
  assign res.status   = status_r;
  assign res.position = pos_wide[ult_pkg::POS_W-1:0];
  assign res.count    = cnt_wide[ult_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/unordered_list_table.sv
// Top level of the unordered list table: sequencer, entry memory and output register.
// Usage:
//   The in_ channel takes one request (in_func, in_value) when in_valid is high
//   and in_stall is low. Operations: append at tail, insert at head, search,
//   and swap-remove. Each request yields exactly one result on the out_ channel
//   (out_status, out_position, out_count), taken when out_valid is high and
//   out_stall is low.
//   Requests are handled one at a time by a sequencer that walks the entry
//   memory, one read per cycle over its single read port. Append writes
//   at the tail; search reads entries in order until a match or the end
//   of the list; head insert shifts each entry up one slot, then writes the
//   head; remove searches, then moves the tail entry into the hole.
//   The result register frees the sequencer: a new request is taken while an
//   earlier result still waits for the receiver. When the receiver stalls and
//   the register is full, the next result holds in the sequencer and in_stall
//   stays high until the register drains.
//   Reset (rst_n low, synchronous) empties the list; the entry memory is not
//   cleared, and the values of entries at or above the count are never used.
`default_nettype none

`include "assert_macros.svh"

module unordered_list_table #(
  parameter int unsigned CAPACITY = ult_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic        [ult_pkg::FUNC_W-1:0]   in_func,
  input  wire logic signed [ult_pkg::DATA_W-1:0]   in_value,
  output logic                                     in_stall,
  output logic                                     out_valid,
  output logic             [ult_pkg::STATUS_W-1:0] out_status,
  output logic             [ult_pkg::POS_W-1:0]    out_position,
  output logic             [ult_pkg::COUNT_W-1:0]  out_count,
  input  wire logic                                out_stall
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ult_pkg::ult_res_t             res;
  logic                          res_ready;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [ult_pkg::DATA_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]              mem_raddr;
  logic [ult_pkg::DATA_W-1:0]    mem_rdata;

  logic                          out_valid_r, out_valid_nxt;
  logic [ult_pkg::STATUS_W-1:0]  out_status_r;
  logic [ult_pkg::POS_W-1:0]     out_position_r;
  logic [ult_pkg::COUNT_W-1:0]   out_count_r;

  ult_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ult_ram #(
    .WIDTH (ult_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load the result register when it is empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status_r   <= res.status;
      out_position_r <= res.position;
      out_count_r    <= res.count;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  // Assertions
  `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall,
               "request accepted but sequencer not busy")
  `ASSERT_IMPLY(a_fail_pos_zero, clk, rst_n,
                out_valid_r && (out_status_r != ult_pkg::ST_OK), out_position_r == '0,
                "failed request reports a nonzero position")
  `ASSERT_IMPLY(a_status_legal, clk, rst_n, out_valid_r,
                (out_status_r == ult_pkg::ST_OK) || (out_status_r == ult_pkg::ST_FULL) ||
                (out_status_r == ult_pkg::ST_NOT_FOUND),
                "illegal status code")
  `ASSERT_NEXT(a_result_held, clk, rst_n, res.valid && !res_ready,
               res.valid && $stable(res.status) && $stable(res.position),
               "pending result lost while output is stalled")

endmodule

`default_nettype wire

FILE: sim/unordered_list_table_tb.sv
// Testbench for the unordered list table: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module unordered_list_table_tb;
  import ult_pkg::*;

  localparam int unsigned CAP       = CAPACITY_DEF;
  localparam int unsigned LONG_HOLD = 200;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic        [FUNC_W-1:0]  in_func = FUNC_APPEND;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic        [STATUS_W-1:0] out_status;
  logic        [POS_W-1:0]    out_position;
  logic        [COUNT_W-1:0]  out_count;
  logic                      out_stall = 1'b0;

  // Predicted list contents and the results still owed by the block
  logic [DATA_W-1:0] list_vals [CAP];
  int unsigned       list_len = 0;
  list_result_t      awaited_results [$];
  list_result_t      next_result;
  int unsigned       error_count = 0;

  // Idle control for the sender and the receiver
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          hold_request = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned stall_left = 0;

  logic [DATA_W-1:0] corner_values [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};

  unordered_list_table uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_func      (in_func),
    .in_value     (in_value),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count),
    .out_stall    (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the predicted list and return the result it owes
  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                 input logic [DATA_W-1:0] key);
    list_result_t res;
    bit           found;
    int unsigned  hit;
    res.status   = ST_OK;
    res.position = '0;
    found = 1'b0;
    hit   = 0;
    case (op)
      FUNC_APPEND, FUNC_HEAD: begin
        if (list_len >= CAP) begin
          res.status = ST_FULL;
        end else if (op == FUNC_APPEND) begin
          list_vals[list_len] = key;
          list_len++;
        end else begin
          for (int i = int'(list_len); i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = key;
          list_len++;
        end
      end
      default: begin
        // Search and remove look for the first valid match
        for (int i = 0; i < int'(list_len); i++) begin
          if (!found && list_vals[i] == key) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (!found) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.position = hit[POS_W-1:0];
          if (op == FUNC_REMOVE) begin
            list_vals[hit] = list_vals[list_len-1];
            list_len--;
          end
        end
      end
    endcase
    res.count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  // Draw a value: mostly present entries for lookups, else random, corner or small
  function automatic logic [DATA_W-1:0] pick_value(input bit lookup);
    if (lookup && list_len != 0 && $urandom_range(0, 3) != 0)
      return list_vals[$urandom_range(0, list_len - 1)];
    case ($urandom_range(0, 2))
      0:       return $urandom;
      1:       return corner_values[$urandom_range(0, 3)];
      default: return DATA_W'($urandom_range(0, 5)) - DATA_W'(2);
    endcase
  endfunction

  // Any operation code at random
  function automatic logic [FUNC_W-1:0] pick_func();
    return FUNC_W'($urandom_range(0, 3));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offer one request; called and returns at a falling edge
  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] key);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func  = op;
    in_value = key;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(apply_list_op(op, key));
    @(negedge clk);
  endtask

  // Hold the sender until every owed result has arrived
  task automatic wait_until_drained();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Check each accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (awaited_results.size() == 0) begin
        report_mismatch("result arrived with no request pending");
      end else begin
        next_result = awaited_results.pop_front();
        if (out_status !== next_result.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, next_result.status));
        if (out_position !== next_result.position)
          report_mismatch($sformatf("position %0d, want %0d", out_position,
                                    next_result.position));
        if (out_count !== next_result.count)
          report_mismatch($sformatf("count %0d, want %0d", out_count, next_result.count));
      end
    end
  end

  // Drive the receiver stall: a random wait after each result, or a long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      stall_left   = LONG_HOLD;
      hold_request = 1'b0;
    end else if (result_taken) begin
      stall_left = recv_quiet ? 0 : $urandom_range(0, 14);
    end
    result_taken = 1'b0;
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Search and remove on a list that is still empty
  task automatic test_empty_list();
    send_request(FUNC_SEARCH, 32'h0);
    send_request(FUNC_REMOVE, 32'h7FFF_FFFF);
  endtask

  // Extreme values at both ends, a hit, a miss and a swap-remove at the head
  task automatic test_boundary_values();
    send_request(FUNC_HEAD, 32'hFFFF_FFFF);
    send_request(FUNC_APPEND, 32'h8000_0000);
    send_request(FUNC_APPEND, 32'h7FFF_FFFF);
    send_request(FUNC_HEAD, 32'h0);
    send_request(FUNC_SEARCH, 32'h7FFF_FFFF);
    send_request(FUNC_SEARCH, 32'h5);
    send_request(FUNC_REMOVE, 32'h0);
  endtask

  // Fill to capacity, refuse both inserts, then remove the tail entry
  task automatic test_full_list();
    while (list_len < CAP) send_request(FUNC_APPEND, $urandom);
    send_request(FUNC_APPEND, 32'h1234_5678);
    send_request(FUNC_HEAD, 32'h8765_4321);
    send_request(FUNC_REMOVE, list_vals[CAP-1]);
  endtask

  // Random bursts that lean toward filling, draining or neither
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned      done;
    int unsigned      mode;
    int unsigned      roll;
    logic [FUNC_W-1:0] op;
    done = 0;
    while (done < n_items) begin
      mode       = $urandom_range(0, 3);
      send_quiet = ($urandom_range(0, 5) == 0);
      recv_quiet = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(20, 60)) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       op = (roll < 40) ? FUNC_APPEND : (roll < 75) ? FUNC_HEAD :
                        (roll < 90) ? FUNC_SEARCH : FUNC_REMOVE;
          1:       op = (roll < 15) ? FUNC_APPEND : (roll < 25) ? FUNC_HEAD :
                        (roll < 45) ? FUNC_SEARCH : FUNC_REMOVE;
          default: op = (roll < 25) ? FUNC_APPEND : (roll < 50) ? FUNC_HEAD :
                        (roll < 75) ? FUNC_SEARCH : FUNC_REMOVE;
        endcase
        send_request(op, pick_value(op == FUNC_SEARCH || op == FUNC_REMOVE));
        done++;
      end
      if ($urandom_range(0, 3) == 0) wait_until_drained();
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    logic [FUNC_W-1:0] op;
    hold_request = 1'b1;
    send_quiet   = 1'b1;
    repeat (12) begin
      op = pick_func();
      send_request(op, pick_value(op == FUNC_SEARCH || op == FUNC_REMOVE));
    end
    send_quiet = 1'b0;
    wait_until_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_boundary_values();
    test_full_list();
    wait_until_drained();
    test_random_mix(500);
    test_backpressure();
    test_random_mix(500);

    // Let any stray result show up before the verdict
    wait_until_drained();
    repeat (CAP + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("unordered_list_table_tb OK");
    end else begin
      $display("unordered_list_table_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("unordered_list_table_tb NOT OK");
    $finish;
  end

endmodule

FILE: unordered_list_table.f
+incdir+hdl
hdl/ult_pkg.sv
hdl/ult_ram.sv
hdl/ult_ctrl.sv
hdl/unordered_list_table.sv
sim/unordered_list_table_tb.sv
